/* rtl/npms_pkg.sv */
package npms_pkg;

    // Store geometry.
    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int ID_W     = 31;
    localparam int LAT_W    = 25;
    localparam int LON_W    = 26;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = ID_W + LAT_W + LON_W;

    // Absolute differences and their sum. The largest possible sum stays below
    // the all-ones value, which therefore serves as the starting best distance.
    localparam int ALAT_W = LAT_W;
    localparam int ALON_W = LON_W;
    localparam int DIST_W = LON_W + 1;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + 7) / 8) * 8;

    // Opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_LOAD_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

    typedef struct packed {
        logic load_wr;
        logic scan_start;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_addr;
        logic busy;
    } dp_stat_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

/* rtl/npms_ctrl.sv */
module npms_ctrl
    import npms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      opcode,
    input  logic      hold_busy,
    input  dp_stat_t  dp_stat,
    output logic      s_tready,
    output ctrl_cmd_t cmd,
    output result_t   res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && !hold_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        res            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == OP_LOAD) begin
                        res.valid   = 1'b1;
                        res.status  = dp_stat.full ? STATUS_FULL : STATUS_LOAD_OK;
                        cmd.load_wr = !dp_stat.full;
                    end else if (dp_stat.empty) begin
                        res.valid  = 1'b1;
                        res.status = STATUS_EMPTY;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (dp_stat.last_addr) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dp_stat.busy) begin
                    res.valid  = 1'b1;
                    res.status = STATUS_ANSWERED;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/npms_datapath.sv */
module npms_datapath
    import npms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctrl_cmd_t               cmd,
    input  logic [ID_W-1:0]         point_id,
    input  logic signed [LAT_W-1:0] lat_value,
    input  logic signed [LON_W-1:0] lon_value,
    output dp_stat_t                dp_stat,
    output logic [ID_W-1:0]         best_id
);

    logic [ENTRY_W-1:0] mem [MAX_POINTS];

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic              v1_reg;
    logic              v2_reg;

    logic signed [LAT_W-1:0] q_lat_reg;
    logic signed [LON_W-1:0] q_lon_reg;

    logic [ALAT_W-1:0] alat_reg;
    logic [ALON_W-1:0] alon_reg;
    logic [ID_W-1:0]   id2_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [ID_W-1:0]   best_id_reg;

    logic signed [LAT_W-1:0] m_lat;
    logic signed [LON_W-1:0] m_lon;
    logic signed [LAT_W:0]   dlat;
    logic signed [LON_W:0]   dlon;
    logic [LAT_W:0]          dlat_abs;
    logic [LON_W:0]          dlon_abs;
    logic [DIST_W-1:0]       cand_dist;
    logic [CNT_W-1:0]        last_idx;

    // Memory word layout, from the lowest bit: id, latitude, longitude.
    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            mem[count_reg[ADDR_W-1:0]] <= {lon_value, lat_value, point_id};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    assign last_idx          = count_reg - CNT_W'(1);
    assign dp_stat.full      = (count_reg == CNT_W'(MAX_POINTS));
    assign dp_stat.empty     = (count_reg == '0);
    assign dp_stat.last_addr = (CNT_W'(rd_addr_reg) == last_idx);
    assign dp_stat.busy      = v1_reg || v2_reg;
    assign best_id           = best_id_reg;

    // Stage two: absolute coordinate differences.
    assign m_lat    = rd_data_reg[ID_W +: LAT_W];
    assign m_lon    = rd_data_reg[ID_W + LAT_W +: LON_W];
    assign dlat     = (LAT_W + 1)'(q_lat_reg) - (LAT_W + 1)'(m_lat);
    assign dlon     = (LON_W + 1)'(q_lon_reg) - (LON_W + 1)'(m_lon);
    assign dlat_abs = dlat[LAT_W] ? (LAT_W + 1)'(-dlat) : dlat;
    assign dlon_abs = dlon[LON_W] ? (LON_W + 1)'(-dlon) : dlon;

    // Stage three: Manhattan distance against the running best.
    assign cand_dist = DIST_W'(alat_reg) + DIST_W'(alon_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_addr_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            if (cmd.load_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.scan_start) begin
                rd_addr_reg <= '0;
            end else if (cmd.issue) begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            q_lat_reg     <= lat_value;
            q_lon_reg     <= lon_value;
            best_dist_reg <= '1;
        end else if (v2_reg && (cand_dist < best_dist_reg)) begin
            best_dist_reg <= cand_dist;
            best_id_reg   <= id2_reg;
        end
        alat_reg <= ALAT_W'(dlat_abs);
        alon_reg <= ALON_W'(dlon_abs);
        id2_reg  <= rd_data_reg[ID_W-1:0];
    end

endmodule

/* rtl/npms_outbuf.sv */
module npms_outbuf
    import npms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  result_t              res,
    input  logic [ID_W-1:0]      best_id,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [ID_W-1:0]      closest_id,
    output logic [STATUS_W-1:0]  status,
    output logic                 hold_busy
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ID_W-1:0]     out_id_reg;
    logic [ID_W-1:0]     out_id_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic                hold_valid_reg;
    logic                hold_valid_next;
    logic [ID_W-1:0]     hold_id_reg;
    logic [ID_W-1:0]     hold_id_next;
    logic [STATUS_W-1:0] hold_status_reg;
    logic [STATUS_W-1:0] hold_status_next;
    logic [ID_W-1:0]     res_id;
    logic                take;

    assign res_id = (res.status == STATUS_ANSWERED) ? best_id : '0;
    assign take   = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_id_next      = out_id_reg;
        out_status_next  = out_status_reg;
        hold_valid_next  = hold_valid_reg;
        hold_id_next     = hold_id_reg;
        hold_status_next = hold_status_reg;
        if (take) begin
            out_valid_next = 1'b0;
        end
        if (take && hold_valid_reg) begin
            out_valid_next  = 1'b1;
            out_id_next     = hold_id_reg;
            out_status_next = hold_status_reg;
            hold_valid_next = 1'b0;
        end
        if (res.valid) begin
            if (!out_valid_reg || take) begin
                out_valid_next  = 1'b1;
                out_id_next     = res_id;
                out_status_next = res.status;
            end else begin
                hold_valid_next  = 1'b1;
                hold_id_next     = res_id;
                hold_status_next = res.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
        out_id_reg      <= out_id_next;
        out_status_reg  <= out_status_next;
        hold_id_reg     <= hold_id_next;
        hold_status_reg <= hold_status_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign closest_id = out_id_reg;
    assign status     = out_status_reg;
    assign hold_busy  = hold_valid_reg;

endmodule

/* rtl/nearest_point_manhattan_search.sv */
// Nearest stored point by Manhattan distance, found by a linear scan.
// The slave channel carries one beat per command: s_tuser selects a load or
// a query, s_tdata carries the point id and the coordinates. A load appends
// the point to an on-chip store of up to 4096 entries; a query walks every
// stored point in load order and returns the id of the closest one, the
// earliest loaded point winning a tie. The master channel returns exactly one
// beat per command: the id in m_tdata and a status code in m_tuser.
// A load, and a query on an empty store, are answered on acceptance: the
// result is registered in the output register, or in the holding register
// while that is occupied. A query issues one memory read per cycle over the
// stored points, then lets the read, difference and distance stages drain
// before its result is registered; no new beat is accepted until then. The
// single read port of the point store limits the scan to this rate.
// Reset empties the store (the point count returns to zero) and drops any
// result not yet taken. When the receiver stalls, one finished result waits
// in the output register and a second in a holding register behind it; once
// both are occupied, s_tready falls, as it also does while a query runs.
module nearest_point_manhattan_search
    import npms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0: point_id[30:0], lat_value[55:31],
    // lon_value[81:56], zero padding[87:82].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: opcode.
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0: closest_id[30:0], zero padding[31].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser fields from bit 0: status[1:0].
    output logic [STATUS_W-1:0]   m_tuser
);

    ctrl_cmd_t       cmd;
    dp_stat_t        dp_stat;
    result_t         res;
    logic [ID_W-1:0] best_id;
    logic [ID_W-1:0] closest_id;
    logic            hold_busy;

    // Sequencing of loads, empty-store checks and the scan.
    npms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .opcode    (s_tuser[0]),
        .hold_busy (hold_busy),
        .dp_stat   (dp_stat),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .res       (res)
    );

    // Point store, distance pipeline and running best.
    npms_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .point_id  (s_tdata[ID_W-1:0]),
        .lat_value (s_tdata[ID_W +: LAT_W]),
        .lon_value (s_tdata[ID_W + LAT_W +: LON_W]),
        .dp_stat   (dp_stat),
        .best_id   (best_id)
    );

    // Output register with one holding slot so the input side keeps moving.
    npms_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res        (res),
        .best_id    (best_id),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .closest_id (closest_id),
        .status     (m_tuser),
        .hold_busy  (hold_busy)
    );

    assign m_tdata = M_TDATA_W'(closest_id);

endmodule

/* tb/sv/nearest_point_manhattan_search_test.sv */
module nearest_point_manhattan_search_test;
    timeunit 1ns;
    timeprecision 1ps;
    import npms_pkg::*;

    // Clocking and run control. The stall limit has to outlast a query over a
    // full store, during which s_tready stays low, plus the longest sender gap
    // and the longest receiver stall, with a good margin.
    localparam int CLK_PERIOD_NS = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 25000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 140;

    // A home area for realistic traffic, in 1e-5 degree units. Points there
    // sit on a 100-unit grid, so equal distances turn up often.
    localparam int HOME_LAT = 5350000;
    localparam int HOME_LON = -11350000;

    // Extremes of the signed coordinate fields and of the id field.
    localparam logic signed [LAT_W-1:0] LAT_LOWEST  = {1'b1, {(LAT_W-1){1'b0}}};
    localparam logic signed [LAT_W-1:0] LAT_HIGHEST = {1'b0, {(LAT_W-1){1'b1}}};
    localparam logic signed [LON_W-1:0] LON_LOWEST  = {1'b1, {(LON_W-1){1'b0}}};
    localparam logic signed [LON_W-1:0] LON_HIGHEST = {1'b0, {(LON_W-1){1'b1}}};
    localparam logic [ID_W-1:0]         ID_ALL_ONES = {ID_W{1'b1}};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // One expected result beat: the id of the nearest point and the status.
    typedef struct {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } answer_t;

    answer_t answers_due[$];

    // The predictor's own copy of the point store, in load order.
    logic [ID_W-1:0]         point_ids[$];
    logic signed [LAT_W-1:0] point_lats[$];
    logic signed [LON_W-1:0] point_lons[$];

    int failures       = 0;
    int loads_done     = 0;
    int loads_refused  = 0;
    int queries_done   = 0;
    int queries_empty  = 0;
    int queries_tied   = 0;
    int idle_cycles    = 0;

    // Pacing switches: the sender inserts gaps between beats and the receiver
    // holds off m_tready only while these are set.
    bit send_gaps   = 1'b0;
    bit recv_stalls = 1'b0;

    nearest_point_manhattan_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin : clock_gen
        forever #(CLK_PERIOD_NS / 2.0) aclk = ~aclk;
    end

    // Most gaps are short; roughly one in twelve is long enough to let the
    // block fill its output and holding registers and drop s_tready.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Coordinates come from three pools: a grid in the home area, anywhere in
    // the legal range of degrees, and any bit pattern the fields can hold.
    function automatic void pick_coords(output logic signed [LAT_W-1:0] lat,
                                        output logic signed [LON_W-1:0] lon);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            lat = LAT_W'(HOME_LAT + 100 * rand_span(-20, 20));
            lon = LON_W'(HOME_LON + 100 * rand_span(-20, 20));
        end else if (roll < 85) begin
            lat = LAT_W'(rand_span(-9000000, 9000000));
            lon = LON_W'(rand_span(-18000000, 18000000));
        end else begin
            lat = LAT_W'($urandom);
            lon = LON_W'($urandom);
        end
    endfunction

    // Works out the result of one accepted command and updates the store
    // copy. A query scans in load order and only a strictly smaller distance
    // displaces the current best, so the earliest loaded point wins a tie.
    function automatic answer_t predict_answer(input logic op,
                                               input logic [ID_W-1:0] id,
                                               input logic signed [LAT_W-1:0] lat,
                                               input logic signed [LON_W-1:0] lon);
        answer_t ans;
        longint  dlat;
        longint  dlon;
        longint  cur_dist;
        longint  best_dist;
        int      best_idx;
        bit      tied;
        ans.id    = '0;
        best_dist = 0;
        best_idx  = 0;
        tied      = 1'b0;
        if (op == OP_LOAD) begin
            loads_done++;
            if (point_ids.size() >= MAX_POINTS) begin
                loads_refused++;
                ans.status = STATUS_FULL;
            end else begin
                point_ids.push_back(id);
                point_lats.push_back(lat);
                point_lons.push_back(lon);
                ans.status = STATUS_LOAD_OK;
            end
            return ans;
        end
        queries_done++;
        if (point_ids.size() == 0) begin
            queries_empty++;
            ans.status = STATUS_EMPTY;
            return ans;
        end
        for (int i = 0; i < point_ids.size(); i++) begin
            dlat = longint'(lat) - longint'(point_lats[i]);
            dlon = longint'(lon) - longint'(point_lons[i]);
            cur_dist = (dlat < 0 ? -dlat : dlat) + (dlon < 0 ? -dlon : dlon);
            if (i == 0 || cur_dist < best_dist) begin
                best_dist = cur_dist;
                best_idx  = i;
                tied      = 1'b0;
            end else if (cur_dist == best_dist) begin
                tied = 1'b1;
            end
        end
        if (tied) queries_tied++;
        ans.id     = point_ids[best_idx];
        ans.status = STATUS_ANSWERED;
        return ans;
    endfunction

    // Sends one command beat and records its expected result once the block
    // has taken it. s_tvalid is only lowered when a gap is due, so a run of
    // back-to-back beats keeps it high without a glitch.
    task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                             input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - ENTRY_W){1'b0}}, lon, lat, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        answers_due.push_back(predict_answer(op, id, lat, lon));
    endtask

    // Takes the sender off the bus and waits for every outstanding result,
    // then lets the clock run on so that any stray extra beat would be seen.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (answers_due.size() > 0 && waited < STALL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A query before anything has been loaded must report an empty store,
    // whatever the id and coordinates carried with it.
    task automatic test_empty_store();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_item(OP_QUERY, ID_ALL_ONES, LAT_HIGHEST, LON_LOWEST);
        send_item(OP_QUERY, '0, '0, '0);
        drain_results();
    endtask

    // Points at the corners of the field ranges, both the bit-pattern limits
    // and the legal degree limits, so that the distance sum reaches its
    // largest value and every id bit is exercised.
    task automatic test_extreme_points();
        send_gaps   = 1'b0;
        recv_stalls = 1'b1;
        send_item(OP_LOAD,  ID_ALL_ONES, LAT_LOWEST, LON_LOWEST);
        send_item(OP_QUERY, '0, LAT_HIGHEST, LON_HIGHEST);
        send_item(OP_LOAD,  '0, LAT_HIGHEST, LON_HIGHEST);
        send_item(OP_QUERY, ID_ALL_ONES, LAT_LOWEST, LON_LOWEST);
        send_item(OP_QUERY, '0, LAT_HIGHEST, LON_HIGHEST);
        send_item(OP_LOAD,  ID_W'(32'h5555_5555), LAT_W'(-9000000), LON_W'(18000000));
        send_item(OP_LOAD,  ID_W'(32'h2AAA_AAAA), LAT_W'(9000000), LON_W'(-18000000));
        send_item(OP_QUERY, '0, LAT_W'(9000000), LON_W'(-18000000));
        send_item(OP_QUERY, '0, LAT_W'(-9000000), LON_W'(18000000));
        drain_results();
    endtask

    // Equal distances from different points, a point loaded twice under two
    // ids, and one id loaded twice at two places.
    task automatic test_tie_breaking();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_item(OP_LOAD,  ID_W'(101), LAT_W'(HOME_LAT + 500), LON_W'(HOME_LON));
        send_item(OP_LOAD,  ID_W'(102), LAT_W'(HOME_LAT - 500), LON_W'(HOME_LON));
        send_item(OP_QUERY, '0, LAT_W'(HOME_LAT), LON_W'(HOME_LON));
        send_item(OP_LOAD,  ID_W'(103), LAT_W'(HOME_LAT), LON_W'(HOME_LON + 200));
        send_item(OP_LOAD,  ID_W'(104), LAT_W'(HOME_LAT), LON_W'(HOME_LON + 200));
        send_item(OP_QUERY, '0, LAT_W'(HOME_LAT), LON_W'(HOME_LON + 200));
        send_item(OP_LOAD,  ID_W'(103), LAT_W'(HOME_LAT), LON_W'(HOME_LON - 200));
        send_item(OP_QUERY, '0, LAT_W'(HOME_LAT), LON_W'(HOME_LON - 300));
        drain_results();
    endtask

    // Mixed loads and queries with random content. Pacing is switched in
    // blocks of twenty beats so that stretches without sender gaps and stretches
    // without receiver stalls occur too. Many queries land on or next to a
    // stored point, which gives exact hits and ties on the grid.
    task automatic test_random_traffic();
        logic                    op;
        logic [ID_W-1:0]         id;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        int                      pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_gaps   = ((n / 20) % 3) != 2;
            recv_stalls = ((n / 20) % 3) != 1;
            op = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_QUERY;
            id = ID_W'($urandom);
            pick_coords(lat, lon);
            if (op == OP_LOAD && point_ids.size() > 0 && $urandom_range(0, 9) == 0) begin
                id = point_ids[$urandom_range(0, point_ids.size() - 1)];
            end
            if (op == OP_QUERY && point_ids.size() > 0 && $urandom_range(0, 99) < 40) begin
                pick = $urandom_range(0, point_ids.size() - 1);
                lat  = point_lats[pick] + LAT_W'(100 * rand_span(-2, 2));
                lon  = point_lons[pick] + LON_W'(100 * rand_span(-2, 2));
            end
            send_item(op, id, lat, lon);
        end
        drain_results();
    endtask

    // Fills the store to capacity, then checks that further loads are refused
    // and that queries still scan every entry, the last one included.
    task automatic test_store_full();
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        send_gaps   = 1'b0;
        recv_stalls = 1'b1;
        while (point_ids.size() < MAX_POINTS) begin
            pick_coords(lat, lon);
            send_item(OP_LOAD, ID_W'($urandom), lat, lon);
        end
        send_gaps = 1'b1;
        send_item(OP_LOAD,  ID_ALL_ONES, LAT_HIGHEST, LON_HIGHEST);
        send_item(OP_QUERY, '0, point_lats[MAX_POINTS-1], point_lons[MAX_POINTS-1]);
        send_item(OP_LOAD,  '0, LAT_LOWEST, LON_LOWEST);
        send_item(OP_QUERY, ID_ALL_ONES, '0, '0);
        send_item(OP_QUERY, '0, LAT_LOWEST, LON_HIGHEST);
        drain_results();
    endtask

    // The receiver holds m_tready high, and while stalls are enabled draws a
    // fresh hold-off after each cycle in which it was ready.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (recv_stalls) stall_left = pick_gap();
            end
        end
    end

    // Every result beat is matched against the oldest outstanding prediction.
    always @(posedge aclk) begin : result_check
        answer_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $error("Result beat with no command outstanding: closest_id %0d, status %0d",
                       m_tdata, m_tuser);
                failures++;
            end else begin
                due = answers_due.pop_front();
                if (m_tdata !== M_TDATA_W'(due.id)) begin
                    $error("closest_id: expected %0d, got %0d", due.id, m_tdata);
                    failures++;
                end
                if (m_tuser !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, m_tuser);
                    failures++;
                end
            end
        end
    end

    // The watchdog ends the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $error("No beat accepted for %0d cycles; %0d results outstanding",
                   idle_cycles, answers_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : run
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_store();
        test_extreme_points();
        test_tie_breaking();
        test_random_traffic();
        test_store_full();
        drain_results();
        if (answers_due.size() != 0) begin
            $error("%0d expected results never arrived", answers_due.size());
            failures++;
        end
        $display("Covered %0d loads (%0d refused on a full store) and %0d queries,",
                 loads_done, loads_refused, queries_done);
        $display("%0d of them on an empty store and %0d decided by the earliest point on a tie.",
                 queries_empty, queries_tied);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
